FILE: hw/rtl/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// Shared types and constants for the nearest-neighbor tour block.
// ----------------------------------------------------------------------------
package nnt_pkg;

    localparam int COORD_W = 16;   // Q12.4 coordinate code
    localparam int IDX_W   = 6;    // load-order index
    localparam int CNT_W   = 7;    // point count, holds 0..64
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int WAIT_W  = 2;

    // last value of the settle counter that lets the cell distance pipes settle
    localparam logic [WAIT_W-1:0] WAIT_LAST = 2'd2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FIRST,
        S_EMIT,
        S_SETTLE,
        S_SCAN
    } t_state;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [DIST_W-1:0]  sqd;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_tok;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [COORD_W-1:0] wr_x;
        logic [COORD_W-1:0] wr_y;
        logic               mark_en;
        logic [IDX_W-1:0]   mark_idx;
        logic               clr;
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [CNT_W-1:0]   count;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/nnt_cell.sv
// ----------------------------------------------------------------------------
// nnt_cell
// One point slot: holds a point and its visited flag, computes its squared
// distance to the current point, and folds itself into the passing best word.
// ----------------------------------------------------------------------------
module nnt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [nnt_pkg::IDX_W-1:0]   i_cell_idx,
    input  nnt_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_go,
    input  nnt_pkg::t_tok               i_tok,
    output logic                        o_go,
    output nnt_pkg::t_tok               o_tok,
    output logic [nnt_pkg::COORD_W-1:0] o_x,
    output logic [nnt_pkg::COORD_W-1:0] o_y
);
    import nnt_pkg::*;

    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_vis;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    logic [SQ_W-1:0]    r_dx2;
    logic [SQ_W-1:0]    r_dy2;
    logic [DIST_W-1:0]  r_dist;
    logic               r_go;
    t_tok               r_tok;
    logic               w_live;
    logic               w_take;
    t_tok               n_tok;

    // point slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_ctl.wr_idx == i_cell_idx)) begin
            r_x <= i_ctl.wr_x;
            r_y <= i_ctl.wr_y;
        end
    end

    // visited flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vis <= 1'b0;
        end else if (i_ctl.mark_en && (i_ctl.mark_idx == i_cell_idx)) begin
            r_vis <= 1'b1;
        end
    end

    // distance pipe: |d|, square, sum
    always_ff @(posedge i_clk) begin
        r_dx   <= (r_x > i_ctl.cur_x) ? (r_x - i_ctl.cur_x) : (i_ctl.cur_x - r_x);
        r_dy   <= (r_y > i_ctl.cur_y) ? (r_y - i_ctl.cur_y) : (i_ctl.cur_y - r_y);
        r_dx2  <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_dy2  <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_dist <= DIST_W'(r_dx2) + DIST_W'(r_dy2);
    end

    // strict less-than: on a tie the earlier (lower index) cell keeps it
    always_comb begin
        w_live = ({1'b0, i_cell_idx} < i_ctl.count) && !r_vis;
        w_take = w_live && (!i_tok.found || (r_dist < i_tok.sqd));
        n_tok  = i_tok;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.sqd   = r_dist;
            n_tok.idx   = i_cell_idx;
            n_tok.x     = r_x;
            n_tok.y     = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_go  = r_go;
    assign o_tok = r_tok;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

FILE: hw/rtl/nearest_neighbor_tour.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tour
// Greedy nearest-neighbor tour over up to MAX_POINTS loaded 2-D points.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------
//  point   | in  | i_valid / o_stall  | i_point_x, i_point_y, i_final_point
//  tour    | out | o_valid / i_stall  | o_tour_x, o_tour_y, o_tour_index,
//          |     |                    | o_tour_end
//
//  Loading takes one point word per cycle. After the final word the
//  first tour word is registered in S_FIRST; each later tour word
//  waits in S_SETTLE for the cell distance pipes, then in S_SCAN for
//  the best word walking the cell chain one cell per cycle.
//  o_stall stays high from the final point word until the last tour word
//  is taken. i_stall holds the tour word in its output register.
//  Reset is synchronous; it empties the set and clears all visited flags.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour #(
    parameter int MAX_POINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [nnt_pkg::COORD_W-1:0] i_point_x,
    input  logic [nnt_pkg::COORD_W-1:0] i_point_y,
    input  logic                        i_final_point,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [nnt_pkg::COORD_W-1:0] o_tour_x,
    output logic [nnt_pkg::COORD_W-1:0] o_tour_y,
    output logic [nnt_pkg::IDX_W-1:0]   o_tour_index,
    output logic                        o_tour_end
);
    import nnt_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;     // points in the current set
    logic [CNT_W-1:0]   r_done, n_done;       // tour words produced so far
    logic [WAIT_W-1:0]  r_wait, n_wait;
    logic [COORD_W-1:0] r_cur_x, n_cur_x;     // current tour point
    logic [COORD_W-1:0] r_cur_y, n_cur_y;
    logic [COORD_W-1:0] r_out_x, n_out_x;     // output word register
    logic [COORD_W-1:0] r_out_y, n_out_y;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic               r_out_end, n_out_end;

    t_cell_ctl          w_ctl;
    logic               w_go_start;
    logic               w_go   [0:MAX_POINTS];
    t_tok               w_tok  [0:MAX_POINTS];
    logic [COORD_W-1:0] w_cell_x [0:MAX_POINTS-1];
    logic [COORD_W-1:0] w_cell_y [0:MAX_POINTS-1];

    // ------------------------------------------------------------------
    // Cell chain. The best word enters cell 0 empty and leaves the last
    // cell holding the nearest unvisited point of the set.
    // ------------------------------------------------------------------
    assign w_go[0]  = w_go_start;
    assign w_tok[0] = '0;

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        nnt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_ctl      (w_ctl),
            .i_go       (w_go[g]),
            .i_tok      (w_tok[g]),
            .o_go       (w_go[g+1]),
            .o_tok      (w_tok[g+1]),
            .o_x        (w_cell_x[g]),
            .o_y        (w_cell_y[g])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_final_point) begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    n_state = r_out_end ? S_LOAD : S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (r_wait == WAIT_LAST) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_go[MAX_POINTS]) begin
                    n_state = S_EMIT;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        w_go_start = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
            end
            S_EMIT: begin
                o_valid = 1'b1;
            end
            S_SETTLE: begin
                w_go_start = (r_wait == WAIT_LAST);
            end
            S_FIRST, S_SCAN: begin
                o_stall = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and cell control
    // ------------------------------------------------------------------
    always_comb begin
        n_count   = r_count;
        n_done    = r_done;
        n_wait    = r_wait;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_out_x   = r_out_x;
        n_out_y   = r_out_y;
        n_out_idx = r_out_idx;
        n_out_end = r_out_end;

        w_ctl          = '0;
        w_ctl.wr_idx   = r_count[IDX_W-1:0];
        w_ctl.wr_x     = i_point_x;
        w_ctl.wr_y     = i_point_y;
        w_ctl.cur_x    = r_cur_x;
        w_ctl.cur_y    = r_cur_y;
        w_ctl.count    = r_count;

        case (r_state)
            S_LOAD: begin
                // points beyond capacity are dropped, final flag still counts
                if (i_valid && (r_count < CNT_W'(MAX_POINTS))) begin
                    w_ctl.wr_en = 1'b1;
                    n_count     = r_count + 1'b1;
                end
            end
            S_FIRST: begin
                // tour always starts at the first point loaded
                n_out_x        = w_cell_x[0];
                n_out_y        = w_cell_y[0];
                n_out_idx      = '0;
                n_out_end      = (r_count == CNT_W'(1));
                w_ctl.mark_en  = 1'b1;
                w_ctl.mark_idx = '0;
                n_cur_x        = w_cell_x[0];
                n_cur_y        = w_cell_y[0];
                n_done         = CNT_W'(1);
            end
            S_EMIT: begin
                n_wait = '0;
                if (!i_stall && r_out_end) begin
                    w_ctl.clr = 1'b1;
                    n_count   = '0;
                    n_done    = '0;
                end
            end
            S_SETTLE: begin
                n_wait = r_wait + 1'b1;
            end
            S_SCAN: begin
                if (w_go[MAX_POINTS]) begin
                    n_out_x        = w_tok[MAX_POINTS].x;
                    n_out_y        = w_tok[MAX_POINTS].y;
                    n_out_idx      = w_tok[MAX_POINTS].idx;
                    n_out_end      = (CNT_W'(r_done + 1'b1) == r_count);
                    w_ctl.mark_en  = 1'b1;
                    w_ctl.mark_idx = w_tok[MAX_POINTS].idx;
                    n_cur_x        = w_tok[MAX_POINTS].x;
                    n_cur_y        = w_tok[MAX_POINTS].y;
                    n_done         = r_done + 1'b1;
                end
            end
            default: begin
                n_wait = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_done  <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
        r_out_idx <= n_out_idx;
        r_out_end <= n_out_end;
    end

    assign o_tour_x     = r_out_x;
    assign o_tour_y     = r_out_y;
    assign o_tour_index = r_out_idx;
    assign o_tour_end   = r_out_end;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_go[MAX_POINTS]) |-> w_tok[MAX_POINTS].found)
        else $error("scan finished without an unvisited point");

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a tour word is pending");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_done <= r_count))
        else $error("more tour words than points");
`endif

endmodule
